[design/ids_pkg.sv]
package ids_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned ItemW   = 32;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned CmdW    = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_POP     = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_GET     = 3'd3,
    CMD_SHIFT   = 3'd4,
    CMD_UNSHIFT = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdxW-1:0]  slot_index;
    logic [ItemW-1:0] write_item;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [ItemW-1:0] read_item;
    logic [CntW-1:0]  fill_count;
  } out_item_t;

  // Memory access issued for one command.
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [ItemW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

  // Result fields known at issue time; read data comes from the store.
  typedef struct packed {
    logic            status;
    logic            rd_en;
    logic [CntW-1:0] fill_count;
  } res_info_t;

endpackage

[design/ids_store.sv]
module ids_store
  import ids_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_req_t         req_i,
  output logic [ItemW-1:0] rdata_o,
  output logic             rvalid_o
);

  logic [ItemW-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [ItemW-1:0] rdata_q;
  logic             rvld_q;

  // Read-first: a same-cycle write to the read address returns old data.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvld_q;

endmodule

[design/ids_ctrl.sv]
module ids_ctrl
  import ids_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output mem_req_t  req_o,
  output res_info_t info_o
);

  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            fail;
  logic            full;
  logic            empty;
  logic [CntW-1:0] idx_ext;
  logic [IdxW-1:0] tail_addr;
  logic [IdxW-1:0] last_addr;
  logic [IdxW-1:0] idx_addr;

  assign full      = (count_q == CntW'(Depth));
  assign empty     = (count_q == '0);
  assign idx_ext   = CntW'(item_i.slot_index);
  assign tail_addr = head_q + count_q[IdxW-1:0];
  assign last_addr = head_q + count_q[IdxW-1:0] - IdxW'(1);
  assign idx_addr  = head_q + item_i.slot_index;

  // Ring buffer: logical slot i lives at physical head + i.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    fail        = 1'b0;
    req_o       = '0;
    req_o.wdata = item_i.write_item;
    info_o      = '0;
    unique case (item_i.cmd)
      CMD_APPEND: begin
        if (full) begin
          fail = 1'b1;
        end else begin
          req_o.we    = 1'b1;
          req_o.waddr = tail_addr;
          count_d     = count_q + CntW'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          fail = 1'b1;
        end else begin
          req_o.re    = 1'b1;
          req_o.raddr = last_addr;
          count_d     = count_q - CntW'(1);
        end
      end
      CMD_INSERT: begin
        if (idx_ext >= CntW'(Depth)) begin
          fail = 1'b1;
        end else begin
          req_o.we    = 1'b1;
          req_o.waddr = idx_addr;
          if (count_q <= idx_ext) begin
            count_d = idx_ext + CntW'(1);
          end
        end
      end
      CMD_GET: begin
        if (idx_ext >= count_q) begin
          fail = 1'b1;
        end else begin
          req_o.re    = 1'b1;
          req_o.raddr = idx_addr;
        end
      end
      CMD_SHIFT: begin
        if (empty) begin
          fail = 1'b1;
        end else begin
          // Old front slot becomes the top slot: clear it.
          req_o.re    = 1'b1;
          req_o.raddr = head_q;
          req_o.we    = 1'b1;
          req_o.waddr = head_q;
          req_o.wdata = '0;
          head_d      = head_q + IdxW'(1);
          count_d     = count_q - CntW'(1);
        end
      end
      CMD_UNSHIFT: begin
        if (full) begin
          fail = 1'b1;
        end else begin
          // The new front overwrites the old top slot.
          head_d      = head_q - IdxW'(1);
          req_o.we    = 1'b1;
          req_o.waddr = head_q - IdxW'(1);
          count_d     = count_q + CntW'(1);
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase
    if (!accept_i) begin
      req_o.we = 1'b0;
      req_o.re = 1'b0;
      head_d   = head_q;
      count_d  = count_q;
    end
    info_o.status     = fail;
    info_o.rd_en      = req_o.re;
    info_o.fill_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

[design/ids_out.sv]
module ids_out
  import ids_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  res_info_t        info_i,
  input  logic [ItemW-1:0] rdata_i,
  input  logic             rvalid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o
);

  logic      pend_q, pend_d;
  res_info_t info_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  logic      move;

  assign move       = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || move;

  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (move) begin
      pend_d = 1'b0;
    end
    if (accept_i) begin
      pend_d = 1'b1;
    end
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      info_q <= info_i;
    end
    if (move) begin
      out_q.status     <= info_q.status;
      out_q.fill_count <= info_q.fill_count;
      out_q.read_item  <= (info_q.rd_en && rvalid_i) ? rdata_i : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/indexed_deque_store.sv]
// Channel | Direction | Handshake             | Beat payload
// in      | input     | in_valid_i/in_ready_o | in_item_t (cmd, slot_index, write_item)
// out     | output    | out_valid_o/out_ready_i | out_item_t (status, read_item, fill_count)
//
// Each command is decoded at the accept edge, where the store is read and/or
// written unless it is refused; the result then moves from the read and info
// registers into the output register. With the output taken promptly, one
// beat is accepted per cycle; the single pending-result register sets this.
// Reset clears head, fill count and all entry valid bits, so the store reads
// as zero. A stalled output holds one result plus one in flight, then
// in_ready_o drops.
module indexed_deque_store
  import ids_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic             accept;
  mem_req_t         req;
  res_info_t        info;
  logic [ItemW-1:0] rdata;
  logic             rvalid;

  // Take a beat only when the result path has room for it.
  assign accept = in_valid_i && in_ready_o;

  // Decode the command, advance head and count, issue the store access.
  ids_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .req_o    (req),
    .info_o   (info)
  );

  // Ring storage with read-first behavior and per-entry valid bits.
  ids_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rdata_o  (rdata),
    .rvalid_o (rvalid)
  );

  // Merge read data with the issue-time fields and hold the result beat.
  ids_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .info_i      (info),
    .rdata_i     (rdata),
    .rvalid_i    (rvalid),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[sim/tb_indexed_deque_store.sv]
module tb_indexed_deque_store
  import ids_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The store decodes 3-bit commands but only six are defined; the spare
  // codes must be refused without touching the store.
  localparam logic [CmdW-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE7 = 3'd7;

  // Phases of the random traffic: bias toward filling, draining or neither.
  localparam int PHASE_GROW  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  localparam int IDLE_PCT       = 14;
  localparam int STALL_CYCLES   = 64;
  localparam int DRAIN_CYCLES   = 4;
  localparam int CYCLE_LIMIT    = 200_000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  indexed_deque_store uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Shadow copy of the store, advanced once per accepted command beat.
  logic [ItemW-1:0] shadow_store [Depth];
  logic [CntW-1:0]  shadow_len;

  // Results owed by the block, oldest first.
  out_item_t pending_results [$];

  // Traffic shaping shared by the sender and the receiver.
  bit steady_flow  = 1'b0;  // no idle cycles on either side while set
  int hold_request = 0;     // receiver stall length handed to the ready driver
  int hold_left    = 0;

  int cycle_count        = 0;
  int mismatches         = 0;
  int beats_checked      = 0;
  int refused_commands   = 0;
  int full_store_hits    = 0;
  int input_stall_cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run the command through the shadow store and return the result beat
  // the block has to produce for it.
  function automatic out_item_t predict_command(input in_item_t beat);
    out_item_t        res;
    logic             refused;
    logic [ItemW-1:0] taken;
    logic [IdxW-1:0]  i;
    refused = 1'b0;
    taken   = '0;
    case (beat.cmd)
      CMD_APPEND: begin
        if (shadow_len >= Depth) begin
          refused = 1'b1;
        end else begin
          shadow_store[shadow_len[IdxW-1:0]] = beat.write_item;
          shadow_len = shadow_len + 1'b1;
        end
      end
      CMD_POP: begin
        if (shadow_len == 0) begin
          refused = 1'b1;
        end else begin
          shadow_len = shadow_len - 1'b1;
          taken = shadow_store[shadow_len[IdxW-1:0]];
        end
      end
      CMD_INSERT: begin
        // A 4-bit index always lands inside the store; skipped slots keep
        // whatever they held before.
        shadow_store[beat.slot_index] = beat.write_item;
        if (shadow_len <= CntW'(beat.slot_index)) begin
          shadow_len = CntW'(beat.slot_index) + 1'b1;
        end
      end
      CMD_GET: begin
        if (CntW'(beat.slot_index) >= shadow_len) begin
          refused = 1'b1;
        end else begin
          taken = shadow_store[beat.slot_index];
        end
      end
      CMD_SHIFT: begin
        if (shadow_len == 0) begin
          refused = 1'b1;
        end else begin
          taken = shadow_store[0];
          for (i = '0; i < IdxW'(Depth - 1); i++) begin
            shadow_store[i] = shadow_store[i + IdxW'(1)];
          end
          shadow_store[IdxW'(Depth - 1)] = '0;
          shadow_len = shadow_len - 1'b1;
        end
      end
      CMD_UNSHIFT: begin
        if (shadow_len >= Depth) begin
          refused = 1'b1;
        end else begin
          for (i = IdxW'(Depth - 1); i > '0; i--) begin
            shadow_store[i] = shadow_store[i - IdxW'(1)];
          end
          shadow_store[0] = beat.write_item;
          shadow_len = shadow_len + 1'b1;
        end
      end
      default: refused = 1'b1;
    endcase
    res.status     = refused;
    res.read_item  = refused ? '0 : taken;
    res.fill_count = shadow_len;
    return res;
  endfunction

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output ready: random idling, a steady mode, and long hold-offs on request.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (steady_flow) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor both channels at the edge. Values read here are the ones that
  // were stable before the edge, so handshakes are seen without races.
  always @(posedge clk_i) begin : watch_channels
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d read_item %h fill_count %0d",
                 out_item_o.status, out_item_o.read_item, out_item_o.fill_count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          beats_checked++;
          if (out_item_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item_o.status);
            mismatches++;
          end
          if (out_item_o.read_item !== want.read_item) begin
            $error("read_item: expected %h, got %h", want.read_item, out_item_o.read_item);
            mismatches++;
          end
          if (out_item_o.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count,
                   out_item_o.fill_count);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_ready_o) input_stall_cycles++;
      if (in_valid_i && in_ready_o) begin
        want = predict_command(in_item_i);
        if (want.status) refused_commands++;
        if (want.fill_count == Depth) full_store_hits++;
        pending_results.push_back(want);
      end
    end
  end

  // Offer one command beat and hold it until the block takes it. Idle
  // cycles go in front of the beat, never between valid and acceptance.
  task automatic send_cmd(input logic [CmdW-1:0] op, input logic [IdxW-1:0] idx,
                          input logic [ItemW-1:0] data);
    in_item_t beat;
    beat.cmd        = op;
    beat.slot_index = idx;
    beat.write_item = data;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Weighted command choice; a few percent go to the spare codes.
  function automatic logic [CmdW-1:0] pick_opcode(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return (r % 2 == 0) ? CMD_SPARE6 : CMD_SPARE7;
    case (phase)
      PHASE_GROW: begin
        if (r < 28) return CMD_APPEND;
        if (r < 48) return CMD_UNSHIFT;
        if (r < 60) return CMD_INSERT;
        if (r < 82) return CMD_GET;
        if (r < 91) return CMD_POP;
        return CMD_SHIFT;
      end
      PHASE_DRAIN: begin
        if (r < 10) return CMD_APPEND;
        if (r < 18) return CMD_UNSHIFT;
        if (r < 24) return CMD_INSERT;
        if (r < 46) return CMD_GET;
        if (r < 73) return CMD_POP;
        return CMD_SHIFT;
      end
      default: begin
        if (r < 19) return CMD_APPEND;
        if (r < 34) return CMD_UNSHIFT;
        if (r < 45) return CMD_INSERT;
        if (r < 65) return CMD_GET;
        if (r < 83) return CMD_POP;
        return CMD_SHIFT;
      end
    endcase
  endfunction

  // Mostly aim indexes at the live part of the store so gets succeed and
  // inserts land inside or just past the end; the rest roam the full range.
  function automatic logic [IdxW-1:0] pick_slot(input logic [CmdW-1:0] op);
    int top;
    top = (shadow_len == 0) ? 0 : int'(shadow_len) - 1;
    if (op == CMD_INSERT) top = (int'(shadow_len) >= Depth) ? Depth - 1 : int'(shadow_len);
    if ($urandom_range(0, 99) < 75) return IdxW'($urandom_range(0, top));
    return IdxW'($urandom_range(0, Depth - 1));
  endfunction

  function automatic logic [ItemW-1:0] pick_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return ItemW'($urandom());
  endfunction

  // Corner cases, in order from a freshly reset store.
  task automatic test_directed_corners();
    send_cmd(CMD_POP,     4'd0,  '0);             // empty store: pop refused
    send_cmd(CMD_SHIFT,   4'd0,  '0);             // empty store: shift refused
    send_cmd(CMD_GET,     4'd0,  '0);             // get at the length refused
    send_cmd(CMD_SPARE6,  4'd0,  '0);             // spare codes change nothing
    send_cmd(CMD_SPARE7,  4'd15, 32'hFFFF_FFFF);
    send_cmd(CMD_UNSHIFT, 4'd0,  32'hFFFF_FFFF);  // unshift works on empty
    send_cmd(CMD_INSERT,  4'd0,  32'hA5A5_5A5A);  // insert at the front slot
    send_cmd(CMD_GET,     4'd0,  '0);
    send_cmd(CMD_INSERT,  4'd15, 32'hFFFF_FFFF);  // jump the length to full
    send_cmd(CMD_GET,     4'd7,  '0);             // skipped slot keeps old value
    send_cmd(CMD_APPEND,  4'd0,  32'h1234_5678);  // full store: append refused
    send_cmd(CMD_UNSHIFT, 4'd0,  32'h1234_5678);  // full store: unshift refused
    send_cmd(CMD_GET,     4'd15, '0);
    send_cmd(CMD_SHIFT,   4'd0,  '0);             // top slot clears on shift
    send_cmd(CMD_GET,     4'd14, '0);
    send_cmd(CMD_APPEND,  4'd0,  '0);
    send_cmd(CMD_POP,     4'd0,  '0);
    send_cmd(CMD_UNSHIFT, 4'd0,  32'h8000_0001);  // old top entry falls off
    send_cmd(CMD_GET,     4'd15, '0);
    send_cmd(CMD_GET,     4'd0,  '0);
    send_cmd(CMD_SHIFT,   4'd0,  '0);
    send_cmd(CMD_GET,     4'd15, '0);             // index equal to length refused
    send_cmd(CMD_POP,     4'd0,  '0);
    send_cmd(CMD_INSERT,  4'd0,  32'h7FFF_FFFF);  // inside the length: no growth
  endtask

  // Random commands in phases biased at random to fill, drain or neither, so
  // both the full and the empty corners come up again and again.
  task automatic test_random_mix(input int count);
    int               n;
    int               phase;
    logic [CmdW-1:0]  op;
    phase = PHASE_MIXED;
    for (n = 0; n < count; n++) begin
      if (n % 48 == 0) phase = $urandom_range(PHASE_GROW, PHASE_MIXED);
      op = pick_opcode(phase);
      send_cmd(op, pick_slot(op), pick_item());
    end
  endtask

  // Same traffic with no idle cycles on either side.
  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    test_random_mix(count);
    steady_flow = 1'b0;
  endtask

  // Hold the output off for a long stretch while commands keep coming, so
  // the block fills its result stage and stalls the command channel.
  task automatic test_output_backpressure(input int count);
    steady_flow  = 1'b1;
    hold_request = STALL_CYCLES;
    test_random_mix(count);
    steady_flow  = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    shadow_store = '{default: '0};
    shadow_len = '0;

    test_directed_corners();
    test_random_mix(1300);
    test_back_to_back(300);
    test_output_backpressure(40);
    test_random_mix(290);

    // Drop valid, let every owed result come back, then keep watching for
    // stray beats.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result beats, %0d of them refusals; store hit full %0d times.",
             beats_checked, refused_commands, full_store_hits);
    $display("Command channel was held off for %0d cycles by output back-pressure.",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
